FILE: sv/dmwr_pkg.sv
// shared types, constants and register indexes of the drive mode and wheel ramp block
package dmwr_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int RSP_DEPTH   = 2;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_STRAIGHT_V_THRESH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_TURN_W_THRESH = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEER_W_THRESH     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_GAIN         = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRAIGHT_MAX       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAMP_STEP          = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_CMD_AGE_LIMIT      = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_MS            = 3'd7;

   localparam logic [2:0] MODE_STOP        = 3'd0;
   localparam logic [2:0] MODE_STRAIGHT    = 3'd1;
   localparam logic [2:0] MODE_ZERO_TURN   = 3'd2;
   localparam logic [2:0] MODE_STEER_LEFT  = 3'd3;
   localparam logic [2:0] MODE_STEER_RIGHT = 3'd4;

   localparam logic [9:0]  SPD_ZERO_TURN = 10'd450;
   localparam logic [9:0]  SPD_STEER     = 10'd330;
   localparam logic [10:0] REV_BIT       = 11'h400;
   localparam logic [10:0] MAG_MASK      = 11'h3FF;
   // wheel order front left, front right, rear right, rear left; 1 = reversed forward sign
   localparam logic [3:0]  FWD_NEG       = 4'b0110;

   typedef struct packed {
      logic        is_tick;
      logic [31:0] now_ms;
      logic        lin_neg;
      logic [15:0] lin_abs;
      logic        ang_neg;
      logic [15:0] ang_abs;
   } item_type;

   typedef struct packed {
      logic [14:0] straight_v_thresh;
      logic [14:0] zero_turn_w_thresh;
      logic [14:0] steer_w_thresh;
      logic [15:0] speed_gain;
      logic [9:0]  straight_max;
      logic [9:0]  ramp_step;
      logic [15:0] cmd_age_limit;
      logic [15:0] hold_ms;
   } cfg_type;

   typedef struct packed {
      logic [10:0] wheel_front_left;
      logic [10:0] wheel_front_right;
      logic [10:0] wheel_rear_right;
      logic [10:0] wheel_rear_left;
      logic [2:0]  drive_mode;
      logic        mode_changed;
      logic        servo_realign;
      logic        cmd_valid;
   } rsp_type;

endpackage

FILE: sv/drive_mode_and_wheel_ramp.sv
// top level: register bank, front end and back end of the drive mode and wheel ramp block
//
// Input side looks like a queue: a transaction is taken when push is high and full is low.
// req_type 0 stores a velocity command (no result), req_type 1 is a control tick that
// produces exactly one result: four sign-magnitude wheel words, the drive mode and flags.
// Result side looks like a queue: while empty is low the oldest result sits on the rsp_
// ports, and it is taken when pop is high.
// A tick taken is held in the front queue, then in the result queue, before it is popped.
// Throughput: one transaction per cycle while the result queue has room; the mode, age
// check and ramp for a tick resolve combinationally in the back end, against the mode and
// ramp words left by the tick before. The front queue and the result queue (two entries
// each by default) let either side stall alone; when pop stays low the result queue fills,
// ticks wait in the front queue, and full rises once it is full. Commands ahead of a
// waiting tick still drain. Registers are written through csr_wr_en/csr_index/csr_wdata;
// the user must write them only while the block is idle, which the block does not enforce.
// Synchronous reset empties both queues, restores register defaults, zeroes the command,
// sets stop mode, clears servo alignment and zeroes the ramp words.
module drive_mode_and_wheel_ramp #(
   parameter int QUEUE_DEPTH = dmwr_pkg::QUEUE_DEPTH,
   parameter int RSP_DEPTH   = dmwr_pkg::RSP_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic                               req_type,
   input  logic [31:0]                        req_now_ms,
   input  logic signed [15:0]                 req_lin_vel,
   input  logic signed [15:0]                 req_ang_vel,
   output logic                               empty,
   input  logic                               pop,
   output logic [10:0]                        rsp_wheel_front_left,
   output logic [10:0]                        rsp_wheel_front_right,
   output logic [10:0]                        rsp_wheel_rear_right,
   output logic [10:0]                        rsp_wheel_rear_left,
   output logic [2:0]                         rsp_drive_mode,
   output logic                               rsp_mode_changed,
   output logic                               rsp_servo_realign,
   output logic                               rsp_cmd_valid,
   input  logic                               csr_wr_en,
   input  logic [dmwr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [dmwr_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import dmwr_pkg::*;

   cfg_type  cfg_ff;
   logic     q_valid, q_pop;
   item_type q_item;
   rsp_type  rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.straight_v_thresh  <= 15'd82;
         cfg_ff.zero_turn_w_thresh <= 15'd819;
         cfg_ff.steer_w_thresh     <= 15'd205;
         cfg_ff.speed_gain         <= 16'd1000;
         cfg_ff.straight_max       <= 10'd900;
         cfg_ff.ramp_step          <= 10'd45;
         cfg_ff.cmd_age_limit      <= 16'd1500;
         cfg_ff.hold_ms            <= 16'd3000;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_STRAIGHT_V_THRESH:  cfg_ff.straight_v_thresh  <= csr_wdata[14:0];
            CSR_ZERO_TURN_W_THRESH: cfg_ff.zero_turn_w_thresh <= csr_wdata[14:0];
            CSR_STEER_W_THRESH:     cfg_ff.steer_w_thresh     <= csr_wdata[14:0];
            CSR_SPEED_GAIN:         cfg_ff.speed_gain         <= csr_wdata;
            CSR_STRAIGHT_MAX:       cfg_ff.straight_max       <= csr_wdata[9:0];
            CSR_RAMP_STEP:          cfg_ff.ramp_step          <= csr_wdata[9:0];
            CSR_CMD_AGE_LIMIT:      cfg_ff.cmd_age_limit      <= csr_wdata;
            CSR_HOLD_MS:            cfg_ff.hold_ms            <= csr_wdata;
            default:                cfg_ff                    <= cfg_ff;
         endcase
      end
   end

   dmwr_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_type    (req_type),
      .req_now_ms  (req_now_ms),
      .req_lin_vel (req_lin_vel),
      .req_ang_vel (req_ang_vel),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop)
   );

   dmwr_back #(
      .RSP_DEPTH (RSP_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (empty),
      .rsp_pop   (pop)
   );

   assign rsp_wheel_front_left  = rsp_data.wheel_front_left;
   assign rsp_wheel_front_right = rsp_data.wheel_front_right;
   assign rsp_wheel_rear_right  = rsp_data.wheel_rear_right;
   assign rsp_wheel_rear_left   = rsp_data.wheel_rear_left;
   assign rsp_drive_mode        = rsp_data.drive_mode;
   assign rsp_mode_changed      = rsp_data.mode_changed;
   assign rsp_servo_realign     = rsp_data.servo_realign;
   assign rsp_cmd_valid         = rsp_data.cmd_valid;

endmodule

FILE: sv/dmwr_fifo.sv
// small first-in first-out queue built from registers
module dmwr_fifo #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fifo count beyond depth");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("fifo count did not advance on push");

endmodule

FILE: sv/dmwr_front.sv
// front end: takes transactions, splits velocities into sign and magnitude, queues them
module dmwr_front #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic                req_type,
   input  logic [31:0]         req_now_ms,
   input  logic signed [15:0]  req_lin_vel,
   input  logic signed [15:0]  req_ang_vel,
   output logic                q_valid,
   output dmwr_pkg::item_type  q_item,
   input  logic                q_pop
);
   import dmwr_pkg::*;

   item_type    item_w;
   logic [15:0] lin_u, ang_u;
   logic        q_empty;

   assign lin_u = req_lin_vel;
   assign ang_u = req_ang_vel;

   always_comb begin
      item_w.is_tick = req_type;
      item_w.now_ms  = req_now_ms;
      item_w.lin_neg = lin_u[15];
      // the most negative value maps to magnitude 0x8000
      item_w.lin_abs = lin_u[15] ? (~lin_u + 16'd1) : lin_u;
      item_w.ang_neg = ang_u[15];
      item_w.ang_abs = ang_u[15] ? (~ang_u + 16'd1) : ang_u;
   end

   dmwr_fifo #(
      .WIDTH ($bits(item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (item_w),
      .full  (full),
      .pop   (q_pop),
      .rdata (q_item),
      .empty (q_empty)
   );

   assign q_valid = !q_empty;

endmodule

FILE: sv/dmwr_back.sv
// back end: command store, mode selection, wheel targets, straight ramp, result queue
module dmwr_back #(
   parameter int RSP_DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  dmwr_pkg::cfg_type  cfg,
   input  logic               q_valid,
   input  dmwr_pkg::item_type q_item,
   output logic               q_pop,
   output dmwr_pkg::rsp_type  rsp_data,
   output logic               rsp_empty,
   input  logic               rsp_pop
);
   import dmwr_pkg::*;

   function automatic logic [10:0] ramp_word(input logic [10:0] cur,
                                             input logic [10:0] target,
                                             input logic [9:0]  step);
      logic [9:0]  cm, tm;
      logic        cd, td;
      logic [9:0]  diff;
      cm = cur[9:0];
      cd = cur[10];
      tm = target[9:0];
      td = target[10];
      if ((cd != td) && (cm > step)) begin
         cm = cm - step;
      end else begin
         if (cm < tm) begin
            diff = tm - cm;
            cm   = cm + ((diff < step) ? diff : step);
         end else if (cm > tm) begin
            diff = cm - tm;
            cm   = cm - ((diff < step) ? diff : step);
         end
         cd = td;
      end
      return {cd, cm};
   endfunction

   logic [31:0] stamp_ff;
   logic        lin_neg_ff, ang_neg_ff;
   logic [15:0] lin_abs_ff, ang_abs_ff;
   logic [2:0]  cur_mode_ff, cur_mode_in;
   logic        aligned_ff, aligned_in;
   logic [10:0] ramp_ff [4];
   logic [10:0] ramp_in [4];

   logic        rsp_full, do_item, do_tick, do_cmd;
   logic [31:0] age;
   logic        turning, valid;
   logic [15:0] va, wa;
   logic        vneg, wneg;
   logic [2:0]  nm;
   logic        changed, realign;
   logic [31:0] prod;
   logic [32:0] rounded;
   logic [20:0] scaled;
   logic [9:0]  straight_mag;
   logic [9:0]  tmag;
   logic        tneg [4];
   logic [10:0] target_w [4];
   rsp_type     rsp_w;

   assign do_item = q_valid && (!q_item.is_tick || !rsp_full);
   assign q_pop   = do_item;
   assign do_tick = do_item && q_item.is_tick;
   assign do_cmd  = do_item && !q_item.is_tick;

   // command age and validity
   assign age     = q_item.now_ms - stamp_ff;
   assign turning = (cur_mode_ff == MODE_ZERO_TURN) || (cur_mode_ff == MODE_STEER_LEFT)
                 || (cur_mode_ff == MODE_STEER_RIGHT);
   assign valid   = (age <= {16'd0, cfg.cmd_age_limit})
                 || (turning && (age <= {16'd0, cfg.hold_ms}));
   assign va      = valid ? lin_abs_ff : 16'd0;
   assign wa      = valid ? ang_abs_ff : 16'd0;
   assign vneg    = valid && lin_neg_ff;
   assign wneg    = valid && ang_neg_ff;

   always_comb begin
      if (valid && (va < {1'b0, cfg.straight_v_thresh})
          && (wa > {1'b0, cfg.zero_turn_w_thresh})) begin
         nm = MODE_ZERO_TURN;
      end else if (valid && (va >= {1'b0, cfg.straight_v_thresh})) begin
         if (!wneg && (wa > {1'b0, cfg.steer_w_thresh})) begin
            nm = MODE_STEER_LEFT;
         end else if (wneg && (wa > {1'b0, cfg.steer_w_thresh})) begin
            nm = MODE_STEER_RIGHT;
         end else begin
            nm = MODE_STRAIGHT;
         end
      end else begin
         nm = MODE_STOP;
      end
   end

   assign changed = (nm != cur_mode_ff);

   always_comb begin
      aligned_in = aligned_ff;
      realign    = 1'b0;
      if (changed) begin
         if ((nm == MODE_STOP) || (nm == MODE_ZERO_TURN)) begin
            aligned_in = 1'b0;
         end else if (!aligned_ff) begin
            aligned_in = 1'b1;
            realign    = 1'b1;
         end
      end
   end

   // straight speed: round half away from zero, then clamp
   assign prod         = 32'(va) * 32'(cfg.speed_gain);
   assign rounded      = {1'b0, prod} + 33'd2048;
   assign scaled       = rounded[32:12];
   assign straight_mag = (scaled > 21'(cfg.straight_max)) ? cfg.straight_max : scaled[9:0];

   always_comb begin
      case (nm)
         MODE_ZERO_TURN:   tmag = SPD_ZERO_TURN;
         MODE_STEER_LEFT:  tmag = SPD_STEER;
         MODE_STEER_RIGHT: tmag = SPD_STEER;
         MODE_STRAIGHT:    tmag = straight_mag;
         default:          tmag = 10'd0;
      endcase
      for (int i = 0; i < 4; i++) begin
         tneg[i]     = (nm == MODE_ZERO_TURN) ? !wneg : (vneg ^ FWD_NEG[i]);
         target_w[i] = (tneg[i] && (tmag != 10'd0)) ? ({1'b0, tmag} | REV_BIT)
                                                    : ({1'b0, tmag} & MAG_MASK);
         ramp_in[i]  = (nm == MODE_STRAIGHT) ? ramp_word(ramp_ff[i], target_w[i], cfg.ramp_step)
                                             : target_w[i];
      end
   end

   assign cur_mode_in = nm;

   always_comb begin
      rsp_w.wheel_front_left  = ramp_in[0];
      rsp_w.wheel_front_right = ramp_in[1];
      rsp_w.wheel_rear_right  = ramp_in[2];
      rsp_w.wheel_rear_left   = ramp_in[3];
      rsp_w.drive_mode        = nm;
      rsp_w.mode_changed      = changed;
      rsp_w.servo_realign     = realign;
      rsp_w.cmd_valid         = valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stamp_ff    <= '0;
         lin_neg_ff  <= 1'b0;
         lin_abs_ff  <= '0;
         ang_neg_ff  <= 1'b0;
         ang_abs_ff  <= '0;
         cur_mode_ff <= MODE_STOP;
         aligned_ff  <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            ramp_ff[i] <= '0;
         end
      end else begin
         if (do_cmd) begin
            stamp_ff   <= q_item.now_ms;
            lin_neg_ff <= q_item.lin_neg;
            lin_abs_ff <= q_item.lin_abs;
            ang_neg_ff <= q_item.ang_neg;
            ang_abs_ff <= q_item.ang_abs;
         end
         if (do_tick) begin
            cur_mode_ff <= cur_mode_in;
            aligned_ff  <= aligned_in;
            for (int i = 0; i < 4; i++) begin
               ramp_ff[i] <= ramp_in[i];
            end
         end
      end
   end

   dmwr_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (do_tick),
      .wdata (rsp_w),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .rdata (rsp_data),
      .empty (rsp_empty)
   );

   a_realign_on_entry: assert property (@(posedge clock) disable iff (reset)
      (do_tick && realign) |-> (changed && ((nm == MODE_STRAIGHT)
         || (nm == MODE_STEER_LEFT) || (nm == MODE_STEER_RIGHT))))
      else $error("servo realign outside a driving mode entry");

   a_invalid_stops: assert property (@(posedge clock) disable iff (reset)
      (do_tick && !valid) |-> (nm == MODE_STOP))
      else $error("stale command left a driving mode");

   a_mode_tracks: assert property (@(posedge clock) disable iff (reset)
      do_tick |=> (cur_mode_ff == $past(nm)))
      else $error("current mode does not follow the last tick");

   a_cmd_no_result: assert property (@(posedge clock) disable iff (reset)
      do_cmd |=> $stable(cur_mode_ff) && $stable(aligned_ff))
      else $error("command transaction changed mode state");

endmodule

FILE: dv/drive_ramp_checker.sv
// watches both channels and the register port, predicts every tick result and compares it
module drive_ramp_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  logic                             full,
   input  logic                             req_type,
   input  logic [31:0]                      req_now_ms,
   input  logic signed [15:0]               req_lin_vel,
   input  logic signed [15:0]               req_ang_vel,
   input  logic                             empty,
   input  logic                             pop,
   input  logic [10:0]                      rsp_wheel_front_left,
   input  logic [10:0]                      rsp_wheel_front_right,
   input  logic [10:0]                      rsp_wheel_rear_right,
   input  logic [10:0]                      rsp_wheel_rear_left,
   input  logic [2:0]                       rsp_drive_mode,
   input  logic                             rsp_mode_changed,
   input  logic                             rsp_servo_realign,
   input  logic                             rsp_cmd_valid,
   input  logic                             csr_wr_en,
   input  logic [dmwr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dmwr_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int unsigned                      fail_count,
   output int unsigned                      pending,
   output int unsigned                      tick_count,
   output int unsigned                      cmd_count,
   output int unsigned                      realign_count,
   output logic [4:0]                       modes_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import dmwr_pkg::*;

   cfg_type            regs;
   logic [31:0]        cmd_stamp;
   logic signed [15:0] cmd_lin;
   logic signed [15:0] cmd_ang;
   logic [2:0]         mode_now;
   bit                 aligned;
   logic [10:0]        ramp_word [4];
   rsp_type            due_results [$];

   initial begin
      fail_count    = 0;
      pending       = 0;
      tick_count    = 0;
      cmd_count     = 0;
      realign_count = 0;
      modes_seen    = '0;
   end

   task automatic report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   task automatic check_field(string name, logic [10:0] got, logic [10:0] want);
      if (got !== want)
         report_mismatch($sformatf("tick result %0d, %s = %0h, expected %0h",
                                   tick_count, name, got, want));
   endtask

   // mode choice, flags, wheel targets and ramp for one control tick; updates the state
   function automatic rsp_type steer_and_ramp(logic [31:0] now);
      logic [31:0] age;
      bit          valid;
      bit          changed;
      bit          realign;
      bit          neg;
      int          v;
      int          w;
      int          va;
      int          wa;
      int          st;
      int          step;
      int          cm;
      int          tm;
      int          mag;
      longint      speed;
      logic [2:0]  next_mode;
      logic        cd;
      logic        td;
      logic [10:0] target [4];
      rsp_type     r;

      age   = now - cmd_stamp;
      valid = (age <= 32'(regs.cmd_age_limit));
      if (!valid && (mode_now == MODE_ZERO_TURN || mode_now == MODE_STEER_LEFT ||
                     mode_now == MODE_STEER_RIGHT) && age <= 32'(regs.hold_ms))
         valid = 1'b1;
      v  = valid ? int'(cmd_lin) : 0;
      w  = valid ? int'(cmd_ang) : 0;
      va = (v < 0) ? -v : v;
      wa = (w < 0) ? -w : w;
      st = int'(regs.steer_w_thresh);

      if (valid && va < int'(regs.straight_v_thresh) && wa > int'(regs.zero_turn_w_thresh))
         next_mode = MODE_ZERO_TURN;
      else if (valid && va >= int'(regs.straight_v_thresh)) begin
         if (w > st)
            next_mode = MODE_STEER_LEFT;
         else if (w < -st)
            next_mode = MODE_STEER_RIGHT;
         else
            next_mode = MODE_STRAIGHT;
      end else
         next_mode = MODE_STOP;

      changed = (next_mode != mode_now);
      realign = 1'b0;
      if (changed) begin
         if (next_mode == MODE_STOP || next_mode == MODE_ZERO_TURN)
            aligned = 1'b0;
         else if (!aligned) begin
            aligned = 1'b1;
            realign = 1'b1;
         end
         mode_now = next_mode;
      end

      speed = (longint'(va) * longint'(regs.speed_gain) + 2048) >>> 12;
      if (speed > longint'(regs.straight_max))
         speed = longint'(regs.straight_max);

      for (int i = 0; i < 4; i++) begin
         mag = 0;
         neg = 1'b0;
         case (mode_now)
            MODE_ZERO_TURN: begin
               mag = int'(SPD_ZERO_TURN);
               neg = (w >= 0);
            end
            MODE_STEER_LEFT, MODE_STEER_RIGHT: begin
               mag = int'(SPD_STEER);
               neg = ((v < 0) != FWD_NEG[i]);
            end
            MODE_STRAIGHT: begin
               mag = int'(speed);
               neg = ((v < 0) != FWD_NEG[i]);
            end
            default: ;
         endcase
         // zero magnitude never carries the reverse bit
         target[i] = (neg && mag != 0) ? (REV_BIT | 11'(mag)) : 11'(mag);
      end

      step = int'(regs.ramp_step);
      for (int i = 0; i < 4; i++) begin
         if (mode_now == MODE_STRAIGHT) begin
            cm = int'(ramp_word[i][9:0]);
            cd = ramp_word[i][10];
            tm = int'(target[i][9:0]);
            td = target[i][10];
            // a direction flip first brakes towards zero
            if (cd != td && cm > step)
               cm -= step;
            else begin
               if (cm < tm)
                  cm += (tm - cm < step) ? tm - cm : step;
               else if (cm > tm)
                  cm -= (cm - tm < step) ? cm - tm : step;
               cd = td;
            end
            ramp_word[i] = {cd, 10'(cm)};
         end else
            ramp_word[i] = target[i];
      end

      r.wheel_front_left  = ramp_word[0];
      r.wheel_front_right = ramp_word[1];
      r.wheel_rear_right  = ramp_word[2];
      r.wheel_rear_left   = ramp_word[3];
      r.drive_mode        = mode_now;
      r.mode_changed      = changed;
      r.servo_realign     = realign;
      r.cmd_valid         = valid;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         regs.straight_v_thresh  = 15'd82;
         regs.zero_turn_w_thresh = 15'd819;
         regs.steer_w_thresh     = 15'd205;
         regs.speed_gain         = 16'd1000;
         regs.straight_max       = 10'd900;
         regs.ramp_step          = 10'd45;
         regs.cmd_age_limit      = 16'd1500;
         regs.hold_ms            = 16'd3000;
         cmd_stamp = '0;
         cmd_lin   = '0;
         cmd_ang   = '0;
         mode_now  = MODE_STOP;
         aligned   = 1'b0;
         for (int i = 0; i < 4; i++)
            ramp_word[i] = '0;
         due_results.delete();
         pending = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_STRAIGHT_V_THRESH:  regs.straight_v_thresh  = csr_wdata[14:0];
               CSR_ZERO_TURN_W_THRESH: regs.zero_turn_w_thresh = csr_wdata[14:0];
               CSR_STEER_W_THRESH:     regs.steer_w_thresh     = csr_wdata[14:0];
               CSR_SPEED_GAIN:         regs.speed_gain         = csr_wdata;
               CSR_STRAIGHT_MAX:       regs.straight_max       = csr_wdata[9:0];
               CSR_RAMP_STEP:          regs.ramp_step          = csr_wdata[9:0];
               CSR_CMD_AGE_LIMIT:      regs.cmd_age_limit      = csr_wdata;
               CSR_HOLD_MS:            regs.hold_ms            = csr_wdata;
               default: ;
            endcase
         end

         if (pop && !empty) begin
            if (due_results.size() == 0)
               report_mismatch("result transaction with no tick waiting for it");
            else begin
               want = due_results.pop_front();
               check_field("wheel_front_left", rsp_wheel_front_left, want.wheel_front_left);
               check_field("wheel_front_right", rsp_wheel_front_right,
                           want.wheel_front_right);
               check_field("wheel_rear_right", rsp_wheel_rear_right, want.wheel_rear_right);
               check_field("wheel_rear_left", rsp_wheel_rear_left, want.wheel_rear_left);
               check_field("drive_mode", 11'(rsp_drive_mode), 11'(want.drive_mode));
               check_field("mode_changed", 11'(rsp_mode_changed), 11'(want.mode_changed));
               check_field("servo_realign", 11'(rsp_servo_realign), 11'(want.servo_realign));
               check_field("cmd_valid", 11'(rsp_cmd_valid), 11'(want.cmd_valid));
               modes_seen[want.drive_mode] = 1'b1;
               if (want.servo_realign)
                  realign_count++;
               tick_count++;
            end
         end

         if (push && !full) begin
            if (req_type)
               due_results.push_back(steer_and_ramp(req_now_ms));
            else begin
               cmd_stamp = req_now_ms;
               cmd_lin   = req_lin_vel;
               cmd_ang   = req_ang_vel;
               cmd_count++;
            end
         end
         pending = due_results.size();
      end
   end

endmodule

FILE: dv/tb.sv
// testbench top: clock, reset, register settings and paced stimulus for the drive ramp block
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dmwr_pkg::*;

   // watchdog limit on the run, set well above the slowest run to leave a wide margin
   localparam int unsigned CYCLE_LIMIT    = 300000;
   localparam int          ITEMS_PER_STEP = 155;
   localparam int          SETTINGS_RUN   = 6;

   logic                   clock;
   logic                   reset;
   logic                   push;
   logic                   full;
   logic                   req_type;
   logic [31:0]            req_now_ms;
   logic signed [15:0]     req_lin_vel;
   logic signed [15:0]     req_ang_vel;
   logic                   empty;
   logic                   pop;
   logic [10:0]            rsp_wheel_front_left;
   logic [10:0]            rsp_wheel_front_right;
   logic [10:0]            rsp_wheel_rear_right;
   logic [10:0]            rsp_wheel_rear_left;
   logic [2:0]             rsp_drive_mode;
   logic                   rsp_mode_changed;
   logic                   rsp_servo_realign;
   logic                   rsp_cmd_valid;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int unsigned fail_count;
   int unsigned pending;
   int unsigned tick_count;
   int unsigned cmd_count;
   int unsigned realign_count;
   logic [4:0]  modes_seen;

   cfg_type     cfg_now;
   logic [31:0] clock_ms;
   int          tx_idle_pct;
   int          rx_stall_pct;
   bit          rx_hold_req;
   int unsigned cycle_count;

   drive_mode_and_wheel_ramp dut (.*);

   drive_ramp_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due", cycle_count, pending);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold-off counted here
   initial begin
      int held;
      pop = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            pop <= 1'b0;
            held = 1;
            while (held < 80) begin
               @(negedge clock);
               held++;
            end
         end
         pop <= ($urandom_range(99, 0) >= rx_stall_pct);
      end
   end

   // one input transaction; returns at the falling edge after it was taken
   task automatic send(logic is_tick, logic [31:0] now, logic [15:0] lin, logic [15:0] ang);
      bit taken;
      while ($urandom_range(99, 0) < tx_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push        <= 1'b1;
      req_type    <= is_tick;
      req_now_ms  <= now;
      req_lin_vel <= lin;
      req_ang_vel <= ang;
      // full only moves at the rising edge, so its value here decides the next edge
      taken = 1'b0;
      while (!taken) begin
         taken = !full;
         @(negedge clock);
      end
   endtask

   task automatic tick(logic [31:0] now);
      send(1'b1, now, 16'($urandom), 16'($urandom));
   endtask

   // wait for every due result, then for any command still in flight
   task automatic settle();
      push <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic load_regs(cfg_type c);
      logic [15:0] junk;
      logic [15:0] data;
      for (int i = 0; i < 8; i++) begin
         junk = 16'($urandom);
         case (CSR_INDEX_W'(i))
            CSR_STRAIGHT_V_THRESH:  data = {junk[15], c.straight_v_thresh};
            CSR_ZERO_TURN_W_THRESH: data = {junk[15], c.zero_turn_w_thresh};
            CSR_STEER_W_THRESH:     data = {junk[15], c.steer_w_thresh};
            CSR_SPEED_GAIN:         data = c.speed_gain;
            CSR_STRAIGHT_MAX:       data = {junk[15:10], c.straight_max};
            CSR_RAMP_STEP:          data = {junk[15:10], c.ramp_step};
            CSR_CMD_AGE_LIMIT:      data = c.cmd_age_limit;
            default:                data = c.hold_ms;
         endcase
         csr_wr_en <= 1'b1;
         csr_index <= CSR_INDEX_W'(i);
         csr_wdata <= data;
         @(negedge clock);
      end
      csr_wr_en <= 1'b0;
      cfg_now = c;
   endtask

   function automatic cfg_type setting_for(int step);
      cfg_type c;
      case (step)
         0: begin
            c.straight_v_thresh = 82;   c.zero_turn_w_thresh = 819;
            c.steer_w_thresh    = 205;  c.speed_gain         = 1000;
            c.straight_max      = 900;  c.ramp_step          = 45;
            c.cmd_age_limit     = 1500; c.hold_ms            = 3000;
         end
         1: begin
            c = '0;
            c.ramp_step = 1;
         end
         2: begin
            c.straight_v_thresh = 15'h7FFF; c.zero_turn_w_thresh = 15'h7FFF;
            c.steer_w_thresh    = 15'h7FFF; c.speed_gain         = 16'hFFFF;
            c.straight_max      = 10'h3FF;  c.ramp_step          = 10'h3FF;
            c.cmd_age_limit     = 16'hFFFF; c.hold_ms            = 16'hFFFF;
         end
         3, 4: begin
            c.straight_v_thresh  = 15'($urandom_range(600, 0));
            c.zero_turn_w_thresh = 15'($urandom_range(4000, 0));
            c.steer_w_thresh     = 15'($urandom_range(2000, 0));
            c.speed_gain         = 16'($urandom_range(65535, 0));
            c.straight_max       = 10'($urandom_range(1023, 0));
            c.ramp_step          = 10'($urandom_range(200, 1));
            c.cmd_age_limit      = 16'($urandom_range(65535, 0));
            c.hold_ms            = 16'($urandom_range(65535, 0));
         end
         default: begin
            c.straight_v_thresh  = 15'($urandom_range(32767, 0));
            c.zero_turn_w_thresh = 15'($urandom_range(32767, 0));
            c.steer_w_thresh     = 15'($urandom_range(32767, 0));
            c.speed_gain         = 16'($urandom_range(65535, 0));
            c.straight_max       = 10'($urandom_range(1023, 0));
            c.ramp_step          = 10'($urandom_range(1023, 1));
            c.cmd_age_limit      = 16'($urandom_range(65535, 0));
            c.hold_ms            = 16'($urandom_range(65535, 0));
         end
      endcase
      return c;
   endfunction

   function automatic int mag_at_least(int lo);
      if (lo >= 32768)
         return 32768;
      if ($urandom_range(3, 0) == 0)
         return lo;
      return int'($urandom_range(32768, lo));
   endfunction

   function automatic int mag_below(int hi);
      if (hi <= 0)
         return 0;
      if ($urandom_range(3, 0) == 0)
         return hi - 1;
      return int'($urandom_range(hi - 1, 0));
   endfunction

   function automatic logic [15:0] with_sign(int mag, bit neg);
      if (!neg && mag > 32767)
         mag = 32767;
      return 16'(neg ? -mag : mag);
   endfunction

   // ages cluster on the timeout and hold edges
   function automatic logic [31:0] pick_age();
      logic [31:0] to_ms;
      logic [31:0] hold;
      to_ms = 32'(cfg_now.cmd_age_limit);
      hold  = 32'(cfg_now.hold_ms);
      case ($urandom_range(9, 0))
         0, 1, 2, 3: return $urandom_range(to_ms, 0);
         4:          return to_ms;
         5:          return to_ms + 1;
         6:          return hold;
         7:          return hold + 1;
         8:          return $urandom_range(hold, 0);
         default:    return $urandom;
      endcase
   endfunction

   // one command followed by a few ticks at chosen ages, or now and then a stray transaction
   task automatic run_sequence(inout int sent);
      int          vthr;
      int          zthr;
      int          sthr;
      int          n;
      logic [15:0] lin;
      logic [15:0] ang;
      logic [31:0] age;
      logic [31:0] longest;
      if ($urandom_range(9, 0) == 0) begin
         send(1'($urandom), $urandom, 16'($urandom), 16'($urandom));
         sent++;
         return;
      end
      vthr = int'(cfg_now.straight_v_thresh);
      zthr = int'(cfg_now.zero_turn_w_thresh);
      sthr = int'(cfg_now.steer_w_thresh);
      case ($urandom_range(9, 0))
         0, 1, 2: begin
            lin = with_sign(mag_at_least(vthr), 1'($urandom));
            ang = with_sign(mag_below(sthr + 1), 1'($urandom));
         end
         3: begin
            lin = with_sign(mag_at_least(vthr), 1'($urandom));
            ang = with_sign(mag_at_least(sthr + 1), 1'b0);
         end
         4: begin
            lin = with_sign(mag_at_least(vthr), 1'($urandom));
            ang = with_sign(mag_at_least(sthr + 1), 1'b1);
         end
         5, 6: begin
            lin = with_sign(mag_below(vthr), 1'($urandom));
            ang = with_sign(mag_at_least(zthr + 1), 1'($urandom));
         end
         7: begin
            lin = with_sign(mag_below(vthr), 1'($urandom));
            ang = with_sign(mag_below(zthr + 1), 1'($urandom));
         end
         default: begin
            lin = 16'($urandom);
            ang = 16'($urandom);
         end
      endcase
      send(1'b0, clock_ms, lin, ang);
      sent++;
      n       = $urandom_range(6, 1);
      longest = 0;
      for (int k = 0; k < n; k++) begin
         age = pick_age();
         if (age > longest)
            longest = age;
         tick(clock_ms + age);
         sent++;
      end
      clock_ms = clock_ms + longest + $urandom_range(40, 1);
   endtask

   initial begin
      int sent;
      int total;
      cycle_count = 0;
      rx_hold_req = 1'b0;
      tx_idle_pct = 0;
      rx_stall_pct = 0;
      reset       = 1'b1;
      push        = 1'b0;
      req_type    = 1'b0;
      req_now_ms  = '0;
      req_lin_vel = '0;
      req_ang_vel = '0;
      csr_wr_en   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      total       = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part on reset register values
      tick(32'd0);
      send(1'b0, 32'd10, 16'sh7FFF, 16'sd0);
      tick(32'd20);
      tick(32'd30);
      send(1'b0, 32'd40, 16'h8000, 16'sd0);
      tick(32'd50);
      tick(32'd60);
      tick(32'd70);
      send(1'b0, 32'd80, 16'sd82, 16'sd205);
      tick(32'd90);
      send(1'b0, 32'd100, 16'sd82, 16'sd206);
      tick(32'd110);
      send(1'b0, 32'd120, -16'sd100, -16'sd206);
      tick(32'd130);
      send(1'b0, 32'd140, 16'sd81, 16'sd820);
      tick(32'd150);
      tick(32'd1641);
      tick(32'd3141);
      send(1'b0, 32'd3200, 16'sd0, 16'h8000);
      tick(32'd4700);
      send(1'b0, 32'hFFFF_FF00, 16'sd4000, 16'sd0);
      tick(32'h0000_0100);
      tick(32'h0000_06DD);
      send(1'b0, 32'h0000_0800, 16'h8000, 16'sh7FFF);
      tick(32'h0000_0810);
      total = 25;
      settle();

      for (int step = 0; step < SETTINGS_RUN; step++) begin
         load_regs(setting_for(step));
         case (step % 4)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 85; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 85; end
            default: begin tx_idle_pct = 26; rx_stall_pct = 26; end
         endcase
         clock_ms = $urandom;
         sent     = 0;
         if (step == 0) begin
            // receiver holds off while ticks keep coming until the input side backs up
            rx_hold_req = 1'b1;
            send(1'b0, clock_ms, 16'sd3000, 16'sd0);
            for (int k = 0; k < 14; k++)
               tick(clock_ms + 32'(k));
            sent     = 15;
            clock_ms = clock_ms + 20;
            settle();
         end
         while (sent < ITEMS_PER_STEP)
            run_sequence(sent);
         total += sent;
         settle();
      end

      $display("covered %0d input transactions (%0d commands, %0d ticks checked) over %0d",
               total, cmd_count, tick_count, SETTINGS_RUN + 1);
      $display("register settings; drive modes seen %05b, servo realigns %0d",
               modes_seen, realign_count);
      if (fail_count == 0 && pending == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

FILE: filelist.f
sv/dmwr_pkg.sv
sv/dmwr_fifo.sv
sv/dmwr_front.sv
sv/dmwr_back.sv
sv/drive_mode_and_wheel_ramp.sv
dv/drive_ramp_checker.sv
dv/tb.sv
